/* rtl/core/bdl_pkg.sv */
// shared constants for the button debouncer with press lockout
// no dependencies; imported by the top level
package bdl_pkg;

  localparam int NumButtonsDef = 4;
  localparam int LevelW        = 4;
  localparam int StampW        = 32;
  localparam int TimeW         = 16;
  localparam int CfgIdxW       = 2;
  localparam int CfgDataW      = 16;
  localparam int InDataW       = 40;
  localparam int OutDataW      = 8;

  localparam logic [TimeW-1:0]  DebounceRst = 16'd30;
  localparam logic [TimeW-1:0]  LockRst     = 16'd150;
  localparam logic [LevelW-1:0] MaskRst     = 4'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDebounce = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLock     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMask     = 2'd2;

endpackage

/* rtl/core/button_debounce_with_lockout.sv */
// top level of the time-based button debouncer with a press lockout
// depends on bdl_pkg for widths, register indexes and reset values
//
// path: an accepted poll is held in the input register, then moves into the result register
// throughput: one poll per cycle while the output is not stalled; per-button settle and lockout compares are parallel
// reset: rst_ni async active low clears all per-button state and restores the
//   configuration defaults (debounce 30, lock 150, mask 3); no clearing pass
module button_debounce_with_lockout #(
  parameter int NumButtons = bdl_pkg::NumButtonsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // poll input; tdata: now_ms[31:0], raw_levels[35:32], zero pad [39:36]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bdl_pkg::InDataW-1:0]   s_axis_tdata,
  // result; tdata: stable_pressed[3:0], just_pressed[7:4]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bdl_pkg::OutDataW-1:0]  m_axis_tdata,
  // configuration write channel, always ready
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bdl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bdl_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bdl_pkg::*;

  // configuration registers
  logic [TimeW-1:0]  debounce_q, lock_q;
  logic [LevelW-1:0] mask_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceRst;
      lock_q     <= LockRst;
      mask_q     <= MaskRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegDebounce: debounce_q <= cfg_data_i;
        RegLock:     lock_q     <= cfg_data_i;
        RegMask:     mask_q     <= cfg_data_i[LevelW-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // pipeline control: input register, then result register
  logic               in_vld_q;
  logic [StampW-1:0]  in_now_q;
  logic [LevelW-1:0]  in_raw_q;
  logic               out_vld_q;
  logic               advance;   // input register moves into the result register
  logic               s_xfer;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_xfer)        in_vld_q <= 1'b1;
      else if (advance)  in_vld_q <= 1'b0;
      if (advance)                 out_vld_q <= 1'b1;
      else if (m_axis_tready)      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_now_q <= s_axis_tdata[StampW-1:0];
      in_raw_q <= s_axis_tdata[StampW +: LevelW];
    end
  end

  // per-button state
  logic              last_raw_q [NumButtons];
  logic              stable_q   [NumButtons];
  logic              seen_q     [NumButtons];
  logic [StampW-1:0] change_q   [NumButtons];
  logic [StampW-1:0] press_q    [NumButtons];

  logic [NumButtons-1:0] stable_d;
  logic [NumButtons-1:0] pulse_d;

  for (genvar i = 0; i < NumButtons; i++) begin : g_btn
    logic              lvl, lock_bit, changed, settled, flip, unlocked;
    logic [StampW-1:0] stamp, since_change, since_press, need;

    // lanes past the field width see a released pin and no lock
    if (i < LevelW) begin : g_in
      assign lvl      = in_raw_q[i];
      assign lock_bit = mask_q[i];
    end else begin : g_none
      assign lvl      = 1'b0;
      assign lock_bit = 1'b0;
    end

    assign changed      = lvl != last_raw_q[i];
    assign stamp        = changed ? in_now_q : change_q[i];
    assign since_change = in_now_q - stamp;
    assign settled      = since_change >= {{(StampW-TimeW){1'b0}}, debounce_q};
    assign flip         = settled && (stable_q[i] != lvl);
    assign need         = lock_bit ? {{(StampW-TimeW){1'b0}}, lock_q} : '0;
    assign since_press  = in_now_q - press_q[i];
    // first press after reset is never locked out
    assign unlocked     = !seen_q[i] || (since_press >= need);

    assign stable_d[i]  = flip ? lvl : stable_q[i];
    assign pulse_d[i]   = flip && lvl && unlocked;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        last_raw_q[i] <= 1'b0;
        stable_q[i]   <= 1'b0;
        seen_q[i]     <= 1'b0;
        change_q[i]   <= '0;
        press_q[i]    <= '0;
      end else if (advance) begin
        last_raw_q[i] <= lvl;
        change_q[i]   <= stamp;
        stable_q[i]   <= stable_d[i];
        if (pulse_d[i]) begin
          press_q[i] <= in_now_q;
          seen_q[i]  <= 1'b1;
        end
      end
    end
  end

  // result register; buttons beyond the field width are dropped
  logic [LevelW-1:0] stable_out, pulse_out;
  logic [LevelW-1:0] stable_res_q, pulse_res_q;

  for (genvar j = 0; j < LevelW; j++) begin : g_out
    if (j < NumButtons) begin : g_have
      assign stable_out[j] = stable_d[j];
      assign pulse_out[j]  = pulse_d[j];
    end else begin : g_zero
      assign stable_out[j] = 1'b0;
      assign pulse_out[j]  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      stable_res_q <= stable_out;
      pulse_res_q  <= pulse_out;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {pulse_res_q, stable_res_q};

`ifndef NO_ASSERTIONS
  // a press pulse only comes with a stable pressed level
  a_pulse_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((pulse_res_q & ~stable_res_q) == '0))
    else $error("just_pressed without stable_pressed");

  // a full input register facing a stalled output must block new polls
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("poll accepted while pipeline is stalled");

  // every item leaving the input register shows up as a result
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("advanced item lost");

  // a pulse on button 0 marks its press as seen
  a_seen_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && pulse_d[0]) |=> seen_q[0])
    else $error("accepted press not recorded");
`endif

endmodule
